// File: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, constants and the rock pattern table of the drum step
// sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

  // fixed pattern geometry
  localparam int unsigned STEPS_PER_BAR = 8;
  localparam int unsigned STEP_W        = 3;
  localparam int unsigned BAR_W         = 6;
  localparam int unsigned PAT_MAX_NOTES = 2;
  localparam int unsigned PAT_IDX_W     = 1;

  // field widths
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // divider sizing
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned DVSR_W  = 10;
  localparam int unsigned DIV_CNT_W = 4;

  // timing and clamp constants
  localparam logic [DIV_W-1:0] MS_PER_MIN = 16'd60000;
  localparam logic [7:0]       BPM_MIN    = 8'd40;
  localparam logic [7:0]       BPM_MAX    = 8'd240;
  localparam logic [7:0]       BARS_MAX   = 8'd32;

  // note numbers and velocity
  localparam logic [NOTE_W-1:0] VEL_ON     = 7'd100;
  localparam logic [NOTE_W-1:0] NOTE_KICK  = 7'd36;
  localparam logic [NOTE_W-1:0] NOTE_SNARE = 7'd38;
  localparam logic [NOTE_W-1:0] NOTE_HAT   = 7'd42;
  localparam logic [NOTE_W-1:0] NOTE_OPEN  = 7'd46;
  localparam logic [NOTE_W-1:0] NOTE_CRASH = 7'd49;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BARS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd3;

  // request commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT,
    ST_DIV_A,
    ST_DIV_B
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic start_init;
    logic stop;
    logic tick_capture;
    logic div_start_a;
    logic div_start_b;
    logic load_len;
    logic eval;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic none;
    logic last_ev;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // number of notes in each pattern step
  function automatic logic [1:0] pat_count(input logic [STEP_W-1:0] step);
    logic [1:0] n;
    case (step)
      3'd1, 3'd5: n = 2'd1;
      default:    n = 2'd2;
    endcase
    return n;
  endfunction

  // note of each pattern step and slot
  function automatic logic [NOTE_W-1:0] pat_note(input logic [STEP_W-1:0] step,
                                                 input logic [PAT_IDX_W-1:0] idx);
    logic [NOTE_W-1:0] n;
    case (step)
      3'd0, 3'd4: n = idx ? NOTE_HAT  : NOTE_KICK;
      3'd1, 3'd5: n = idx ? 7'd0      : NOTE_HAT;
      3'd2, 3'd6: n = idx ? NOTE_HAT  : NOTE_SNARE;
      3'd3, 3'd7: n = idx ? NOTE_OPEN : NOTE_KICK;
      default:    n = 7'd0;
    endcase
    return n;
  endfunction

endpackage

// File: src/drum_step_sequencer.sv
// ----------------------------------------------------------------------------
// drum_step_sequencer
// Plays an eight-step rock pattern as note on/off events, timed by the tick
// count carried on every request.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_ready   in_cmd, in_now_tick
//   out      output     out_valid/out_ready event, note, velocity, program,
//                                           running, last
//   cfg      input      cfg_wr_en           cfg_index, cfg_wr_data
//
// A tick emits its events one after another (up to four: two releases, two strikes).
// A start runs two passes of the shared divider before the step length is loaded.
// Stop and the unused code go straight back to idle. One request is worked at a time.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled output holds the event sequencer until the output register frees.
// ----------------------------------------------------------------------------
module drum_step_sequencer import dss_pkg::*; #(
  parameter int unsigned NOTES_PER_STEP = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [TIME_W-1:0]    in_now_tick,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_event_on,
  output logic [NOTE_W-1:0]    out_note_number,
  output logic [NOTE_W-1:0]    out_strike_velocity,
  output logic [NOTE_W-1:0]    out_event_program,
  output logic                 out_seq_running,
  output logic                 out_last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  dss_datapath #(
    .NOTES_PER_STEP (NOTES_PER_STEP)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wr_data         (cfg_wr_data),
    .in_now_tick         (in_now_tick),
    .cmd                 (cmd),
    .status              (status),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_on        (out_event_on),
    .out_note_number     (out_note_number),
    .out_strike_velocity (out_strike_velocity),
    .out_event_program   (out_event_program),
    .out_seq_running     (out_seq_running),
    .out_last            (out_last)
  );

endmodule

// File: src/dss_div.sv
// ----------------------------------------------------------------------------
// dss_div
// Restoring divider, one quotient bit per cycle; done pulses when the
// quotient register holds the final result.
// ----------------------------------------------------------------------------
module dss_div import dss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic [DIV_W-1:0]  quotient,
  output logic              done
);

  logic [DVSR_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVSR_W-1:0]    dvsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DVSR_W:0]      shifted;
  logic [DVSR_W:0]      trial;

  // one restoring step
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvsr_r};
    if (trial[DVSR_W]) begin
      rem_nxt = shifted[DVSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end else begin
      rem_nxt = trial[DVSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: src/dss_datapath.sv
// ----------------------------------------------------------------------------
// dss_datapath
// Configuration registers, sequencer state, sounding note store, step length
// divider and the output register of the drum step sequencer.
// ----------------------------------------------------------------------------
module dss_datapath import dss_pkg::*; #(
  parameter int unsigned NOTES_PER_STEP = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic [TIME_W-1:0]    in_now_tick,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_event_on,
  output logic [NOTE_W-1:0]    out_note_number,
  output logic [NOTE_W-1:0]    out_strike_velocity,
  output logic [NOTE_W-1:0]    out_event_program,
  output logic                 out_seq_running,
  output logic                 out_last
);

  localparam int unsigned CNT_W  = $clog2(NOTES_PER_STEP + 1);
  localparam int unsigned EV_W   = $clog2(NOTES_PER_STEP + PAT_MAX_NOTES + 1);
  localparam int unsigned NIDX_W = (NOTES_PER_STEP > 1) ? $clog2(NOTES_PER_STEP) : 1;

  // configuration
  logic [7:0]        tempo_r;
  logic [7:0]        bars_r;
  logic [NOTE_W-1:0] prog_cfg_r;
  logic [CFG_W-1:0]  period_r;

  // sequencer state
  logic                 running_r;
  logic [STEP_W-1:0]    step_r;
  logic [BAR_W-1:0]     bar_r;
  logic [BAR_W-1:0]     limit_r;
  logic [NOTE_W-1:0]    prog_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [LEN_W-1:0]     len_r;
  logic [TIME_W-1:0]    due_r;
  logic [TIME_W-1:0]    now_r;
  logic [NOTE_W-1:0]    notes_r [NOTES_PER_STEP];

  // per-item event plan
  logic [CNT_W-1:0]     rel_cnt_r;
  logic [EV_W-1:0]      total_r;
  logic [EV_W-1:0]      ev_idx_r;
  logic [STEP_W-1:0]    on_step_r;
  logic                 crash_r;

  // output register
  logic                 out_valid_r;
  logic                 out_on_r;
  logic [NOTE_W-1:0]    out_note_r;
  logic [NOTE_W-1:0]    out_vel_r;
  logic [NOTE_W-1:0]    out_prog_r;
  logic                 out_run_r;
  logic                 out_last_r;

  // start-time clamps
  logic [7:0]           bpm_c;
  logic [BAR_W-1:0]     bars_c;
  logic [DVSR_W-1:0]    per_c;

  // divider hookup
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DVSR_W-1:0]    div_divisor;
  logic [DIV_W-1:0]     div_quo;
  logic                 div_done;

  // tick evaluation
  logic [TIME_W-1:0]    diff;
  logic                 not_due;
  logic                 play;
  logic [1:0]           pat_n;
  logic [CNT_W-1:0]     on_n;
  logic [EV_W-1:0]      total_n;

  // event selection
  logic                 is_on;
  logic [EV_W-1:0]      j_full;
  logic [PAT_IDX_W-1:0] j;
  logic [NOTE_W-1:0]    pnote;
  logic [NOTE_W-1:0]    ev_note;
  logic                 last_ev;
  logic                 out_free;

  // clamp the configuration used at start
  always_comb begin
    if (tempo_r < BPM_MIN)      bpm_c = BPM_MIN;
    else if (tempo_r > BPM_MAX) bpm_c = BPM_MAX;
    else                        bpm_c = tempo_r;
    if (bars_r == 8'd0)         bars_c = BAR_W'(1);
    else if (bars_r > BARS_MAX) bars_c = BAR_W'(BARS_MAX);
    else                        bars_c = bars_r[BAR_W-1:0];
    per_c = (period_r == '0) ? DVSR_W'(1) : period_r;
  end

  // first pass divides a minute by tempo, second pass the half by tick period
  assign div_start    = cmd.div_start_a | cmd.div_start_b;
  assign div_dividend = cmd.div_start_b ? {1'b0, div_quo[DIV_W-1:1]} : MS_PER_MIN;
  assign div_divisor  = cmd.div_start_b ? per_c : {2'b00, bpm_c};

  dss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  // due check and event plan for a tick
  always_comb begin
    diff    = now_r - due_r;
    not_due = running_r & diff[TIME_W-1];
    play    = running_r & (bar_r < limit_r);
    pat_n   = pat_count(step_r);
    if (!play)                      on_n = '0;
    else if (pat_n > NOTES_PER_STEP) on_n = CNT_W'(NOTES_PER_STEP);
    else                            on_n = CNT_W'(pat_n);
    total_n = EV_W'(cnt_r) + EV_W'(on_n);
  end

  // current event: releases first, then the new strikes
  always_comb begin
    is_on  = ev_idx_r >= EV_W'(rel_cnt_r);
    j_full = ev_idx_r - EV_W'(rel_cnt_r);
    j      = j_full[PAT_IDX_W-1:0];
    pnote  = pat_note(on_step_r, j);
    if (crash_r && pnote == NOTE_HAT) pnote = NOTE_CRASH;
    ev_note = is_on ? pnote : notes_r[ev_idx_r[NIDX_W-1:0]];
    last_ev = (EV_W'(ev_idx_r + 1'b1) == total_r);
  end

  assign out_free = !out_valid_r || out_ready;

  assign status.none     = not_due | (total_n == '0);
  assign status.last_ev  = last_ev;
  assign status.div_done = div_done;
  assign status.out_free = out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r    <= 8'd120;
      bars_r     <= 8'd1;
      prog_cfg_r <= '0;
      period_r   <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TEMPO:  tempo_r    <= cfg_wr_data[7:0];
        CFG_BARS:   bars_r     <= cfg_wr_data[7:0];
        CFG_PROG:   prog_cfg_r <= cfg_wr_data[NOTE_W-1:0];
        CFG_PERIOD: period_r   <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      step_r    <= '0;
      bar_r     <= '0;
      limit_r   <= '0;
      prog_r    <= '0;
      cnt_r     <= '0;
      len_r     <= '0;
      due_r     <= '0;
      rel_cnt_r <= '0;
      total_r   <= '0;
      ev_idx_r  <= '0;
      on_step_r <= '0;
      crash_r   <= 1'b0;
    end else begin
      if (cmd.start_init) begin
        step_r    <= '0;
        bar_r     <= '0;
        limit_r   <= bars_c;
        prog_r    <= prog_cfg_r;
        cnt_r     <= '0;
        due_r     <= in_now_tick;
        running_r <= 1'b1;
      end
      if (cmd.stop) begin
        running_r <= 1'b0;
      end
      if (cmd.load_len) begin
        len_r <= div_quo[LEN_W-1:0];
      end
      // a due tick releases the old step and arms the next one
      if (cmd.eval && !not_due) begin
        rel_cnt_r <= cnt_r;
        total_r   <= total_n;
        ev_idx_r  <= '0;
        cnt_r     <= on_n;
        if (running_r && !play) begin
          running_r <= 1'b0;
        end
        if (play) begin
          on_step_r <= step_r;
          crash_r   <= (bar_r == '0) && (step_r == '0);
          step_r    <= step_r + 1'b1;
          if (step_r == STEP_W'(STEPS_PER_BAR - 1)) begin
            bar_r <= bar_r + 1'b1;
          end
          due_r <= now_r + TIME_W'(len_r);
        end
      end
      if (cmd.emit) begin
        ev_idx_r <= ev_idx_r + 1'b1;
      end
    end
  end

  // captured tick time
  always_ff @(posedge clk) begin
    if (cmd.tick_capture) begin
      now_r <= in_now_tick;
    end
  end

  // sounding note store
  always_ff @(posedge clk) begin
    if (cmd.emit && is_on) begin
      notes_r[NIDX_W'(j)] <= pnote;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_on_r   <= is_on;
      out_note_r <= ev_note;
      out_vel_r  <= is_on ? VEL_ON : '0;
      out_prog_r <= prog_r;
      out_run_r  <= running_r;
      out_last_r <= last_ev;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_on        = out_on_r;
  assign out_note_number     = out_note_r;
  assign out_strike_velocity = out_vel_r;
  assign out_event_program   = out_prog_r;
  assign out_seq_running     = out_run_r;
  assign out_last            = out_last_r;

endmodule

// File: src/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl
// Controller of the drum step sequencer: takes requests, runs the start-time
// division and steps through the events of a tick.
// ----------------------------------------------------------------------------
module dss_ctrl import dss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_START: state_nxt = ST_DIV_A;
            CMD_TICK:  state_nxt = ST_EVAL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EVAL: begin
        state_nxt = status.none ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.last_ev) state_nxt = ST_IDLE;
      end
      ST_DIV_A: begin
        if (status.div_done) state_nxt = ST_DIV_B;
      end
      ST_DIV_B: begin
        if (status.div_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_START: begin
              cmd.start_init  = 1'b1;
              cmd.div_start_a = 1'b1;
            end
            CMD_STOP: cmd.stop         = 1'b1;
            CMD_TICK: cmd.tick_capture = 1'b1;
            default: ;
          endcase
        end
      end
      ST_EVAL:  cmd.eval        = 1'b1;
      ST_EMIT:  cmd.emit        = status.out_free;
      ST_DIV_A: cmd.div_start_b = status.div_done;
      ST_DIV_B: cmd.load_len    = status.div_done;
      default: ;
    endcase
  end

endmodule
